>>> hw/rtl/siu_pkg.sv
// Package for the sorted index union block: payload structs, command and state
// types, input kind and membership codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package siu_pkg;

   localparam int LIST_DEPTH_DEFAULT = 32;
   localparam int INDEX_W            = 31;
   localparam int POS_W              = 6;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QPTR_W             = 2;

   localparam logic [1:0] KIND_FIRST  = 2'd0;
   localparam logic [1:0] KIND_SECOND = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [1:0] MEMB_BOTH      = 2'd0;
   localparam logic [1:0] MEMB_NO_FIRST  = 2'd1;
   localparam logic [1:0] MEMB_NO_SECOND = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] index_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] union_index;
      logic [1:0]         membership;
      logic [POS_W-1:0]   union_position;
      logic               is_empty;
      logic               overflowed;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD_FIRST,
      OP_LOAD_SECOND,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_MERGE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/siu_front.sv
// Front end: accepts input items, classifies them into commands and queues
// them for the back end. Depends on siu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module siu_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  siu_pkg::req_type req_payload,
   output logic             cmd_valid,
   output siu_pkg::cmd_type cmd,
   input  wire              cmd_pop
);

   siu_pkg::cmd_type q_mem_ff [siu_pkg::QUEUE_DEPTH];
   logic [siu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [siu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [siu_pkg::QPTR_W:0]   count_ff, count_in;
   logic                       push;
   logic                       pop;
   siu_pkg::cmd_type           new_cmd;

   assign busy      = (count_ff == (siu_pkg::QPTR_W+1)'(siu_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_mem_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.value = req_payload.index_value;
      new_cmd.op    = siu_pkg::OP_LOAD_FIRST;
      push          = start && !busy;
      unique case (req_payload.kind)
         siu_pkg::KIND_FIRST:  new_cmd.op = siu_pkg::OP_LOAD_FIRST;
         siu_pkg::KIND_SECOND: new_cmd.op = siu_pkg::OP_LOAD_SECOND;
         siu_pkg::KIND_FINISH: new_cmd.op = siu_pkg::OP_FINISH;
         // drop the unused kind: accepted, never queued
         default:              push = 1'b0;
      endcase
      pop       = cmd_pop && cmd_valid;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (siu_pkg::QPTR_W+1)'(push) - (siu_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/siu_back.sv
// Back end: holds both index stores, applies load commands and runs the
// two-pointer merge for finish commands. Depends on siu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module siu_back #(
   parameter int LIST_DEPTH = siu_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              cmd_valid,
   input  siu_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_strobe,
   output siu_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

   logic [siu_pkg::INDEX_W-1:0] store_a [LIST_DEPTH];
   logic [siu_pkg::INDEX_W-1:0] store_b [LIST_DEPTH];

   siu_pkg::state_type          state_ff, state_in;
   logic [CW-1:0]               a_ff, a_in, b_ff, b_in;
   logic [CW-1:0]               cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic                        ovf_ff, ovf_in;
   logic [siu_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [siu_pkg::INDEX_W-1:0] head_a_ff, head_b_ff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   siu_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        wr_a, wr_b;
   logic                        has_a, has_b, take_a, take_b;

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      cmd_pop       = 1'b0;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      has_a         = (a_ff < cnt_a_ff);
      has_b         = (b_ff < cnt_b_ff);
      take_a        = 1'b0;
      take_b        = 1'b0;
      unique case (state_ff)
         siu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  siu_pkg::OP_LOAD_FIRST: begin
                     if (cnt_a_ff < FULL) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  siu_pkg::OP_LOAD_SECOND: begin
                     if (cnt_b_ff < FULL) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  siu_pkg::OP_FINISH: state_in = siu_pkg::ST_PREP;
                  default:            state_in = siu_pkg::ST_IDLE;
               endcase
            end
         end
         siu_pkg::ST_PREP: begin
            // heads of both stores are fetched during this cycle
            if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.is_empty   = 1'b1;
               rsp_in.last       = 1'b1;
               rsp_in.overflowed = ovf_ff;
               ovf_in            = 1'b0;
               state_in          = siu_pkg::ST_IDLE;
            end else begin
               pos_in   = '0;
               state_in = siu_pkg::ST_MERGE;
            end
         end
         siu_pkg::ST_MERGE: begin
            rsp_in.overflowed = ovf_ff;
            rsp_in.union_position = pos_ff;
            if (has_a && has_b) begin
               if (head_a_ff == head_b_ff) begin
                  take_a = 1'b1;
                  take_b = 1'b1;
                  rsp_in.union_index = head_a_ff;
                  rsp_in.membership  = siu_pkg::MEMB_BOTH;
               end else if (head_a_ff > head_b_ff) begin
                  take_b = 1'b1;
                  rsp_in.union_index = head_b_ff;
                  rsp_in.membership  = siu_pkg::MEMB_NO_FIRST;
               end else begin
                  take_a = 1'b1;
                  rsp_in.union_index = head_a_ff;
                  rsp_in.membership  = siu_pkg::MEMB_NO_SECOND;
               end
            end else if (has_a) begin
               take_a = 1'b1;
               rsp_in.union_index = head_a_ff;
               rsp_in.membership  = siu_pkg::MEMB_NO_SECOND;
            end else begin
               take_b = 1'b1;
               rsp_in.union_index = head_b_ff;
               rsp_in.membership  = siu_pkg::MEMB_NO_FIRST;
            end
            a_in          = a_ff + CW'(take_a);
            b_in          = b_ff + CW'(take_b);
            pos_in        = pos_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_in.last   = (a_in == cnt_a_ff) && (b_in == cnt_b_ff);
            if (rsp_in.last) begin
               // empty both stores for the next load
               a_in     = '0;
               b_in     = '0;
               cnt_a_in = '0;
               cnt_b_in = '0;
               ovf_in   = 1'b0;
               state_in = siu_pkg::ST_IDLE;
            end
         end
         default: state_in = siu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= siu_pkg::ST_IDLE;
         a_ff          <= '0;
         b_ff          <= '0;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ovf_ff        <= 1'b0;
         pos_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ovf_ff        <= ovf_in;
         pos_ff        <= pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // stores: one write port, one registered read port each, read at the next pointer
   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a[cnt_a_ff[AW-1:0]] <= cmd.value;
      end
      head_a_ff <= store_a[a_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         store_b[cnt_b_ff[AW-1:0]] <= cmd.value;
      end
      head_b_ff <= store_b[b_in[AW-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.is_empty) |-> rsp_ff.last)
      else $error("empty result without last");

   a_burst_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ff.last) |=> rsp_strobe_ff)
      else $error("gap inside a result burst");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (a_ff <= cnt_a_ff) && (b_ff <= cnt_b_ff) && (cnt_a_ff <= FULL) && (cnt_b_ff <= FULL))
      else $error("merge pointer beyond list count");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != siu_pkg::ST_IDLE) |-> !cmd_pop)
      else $error("command taken while merge runs");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sorted_index_union_with_differences_top.sv
// Top level of the sorted index union block: front end with command queue
// and back end with stores and merge. Depends on siu_pkg, siu_front, siu_back.
//
// Usage: an item (req_payload: kind, index_value) transfers at a rising edge
// with start high and busy low. Kind first or second appends index_value to
// that list; kind finish merges both lists; the unused kind is dropped.
// Accepted items wait in a four-entry command queue; busy is high while the
// queue is full. The back end takes one command at a time; loads sustain one
// item per cycle while no finish is being merged. A finish occupies the back
// end while it takes the command, fetches both list heads, then emits one
// union entry per cycle from the single read port of each store; an empty
// finish gives its single result from the head-fetch step instead.
// Results leave on rsp_payload for one cycle each, marked by rsp_strobe; the
// receiver cannot stall them. The final result of a finish has last set, and
// both stores and the overflow flag are then emptied.
// Reset empties the queue, both lists and the overflow flag; store contents
// are not cleared since only entries below the list counts are ever used.
`timescale 1ns / 1ps
`default_nettype none

module sorted_index_union_with_differences_top #(
   parameter int LIST_DEPTH = siu_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  siu_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output siu_pkg::rsp_type rsp_payload
);

   logic             cmd_valid;
   logic             cmd_pop;
   siu_pkg::cmd_type cmd;

   siu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   siu_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
